// ===== src/ppl_pkg.sv =====
// ----------------------------------------------------------------------------
// ppl_pkg: shared types and constants of the pitch pulse locator
// Field widths, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ppl_pkg;

    // fixed field widths
    localparam int PITCH_W = 16;
    localparam int SCALE_W = 32;
    localparam int PROD_W  = 48;
    localparam int COUNT_W = 32;
    localparam int FRAC_W  = 16;
    localparam int ADDR_W  = 1;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_TURN_SCALE    = 1'd0;
    localparam logic [ADDR_W-1:0] REG_DEFAULT_PITCH = 1'd1;

    // configuration reset values
    localparam logic [SCALE_W-1:0] TURN_SCALE_RST    = 32'd366503876;
    localparam logic [PITCH_W-1:0] DEFAULT_PITCH_RST = 16'd8000;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // take input word
        logic mult;      // register pitch times scale
        logic eval;      // advance phase, set up divider
        logic div_step;  // one restoring division step
        logic load_out;  // load output register
    } ppl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic need_div;  // pulse found and quotient below one
    } ppl_status_t;

endpackage

// ===== src/pitch_pulse_locator_core.sv =====
// ----------------------------------------------------------------------------
// pitch_pulse_locator_core: pitch pulse locator top level
// Input stream: s_tdata carries the pitch, s_tuser the voiced and restart
// flags. Each accepted word yields exactly one output word on the m_ side:
// the pulse flag in m_tuser, the pulse index and shift fraction in m_tdata.
// A wrapping phase advances by the upper PHASE_BITS bits of pitch times
// turn_scale per sample; a jump of more than half a turn marks a pulse at the previous sample index.
// The restoring divider runs only when a pulse is found with a quotient
// below one and yields one quotient bit per cycle. One word is in work at
// a time, so the next word is accepted only once the current one has
// been loaded into the output register.
// The output register lets the next word be accepted while a result waits;
// a stalled receiver holds m_tvalid and the word, and the block waits in its
// output step until the register frees.
// Reset clears phase, sample counter and valid flags and loads the register
// defaults. Configuration writes (cfg_we, cfg_addr, cfg_data) take effect
// at once and must come only while the block is idle.
// ----------------------------------------------------------------------------
module pitch_pulse_locator_core #(
    parameter int PHASE_BITS    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [ppl_pkg::ADDR_W-1:0]     cfg_addr,
    input  logic [ppl_pkg::SCALE_W-1:0]    cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [15:0] pitch
    input  logic [1:0]                     s_tuser,   // [0] voiced, [1] restart
    // output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [47:0]                    m_tdata,   // [31:0] pulse_index,
                                                      // [47:32] shift_fraction
    output logic [0:0]                     m_tuser    // [0] pulse
);
    import ppl_pkg::*;

    ppl_cmd_t           cmd;
    ppl_status_t        status;
    logic               pulse;
    logic [COUNT_W-1:0] pulse_index;
    logic [FRAC_W-1:0]  shift_fraction;

    // controller
    ppl_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    ppl_datapath #(
        .PHASE_BITS    (PHASE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .pitch          (s_tdata[PITCH_W-1:0]),
        .voiced         (s_tuser[0]),
        .restart        (s_tuser[1]),
        .cmd            (cmd),
        .status         (status),
        .pulse          (pulse),
        .pulse_index    (pulse_index),
        .shift_fraction (shift_fraction)
    );

    // output packing
    assign m_tdata = {shift_fraction, pulse_index};
    assign m_tuser = pulse;

`ifndef SYNTHESIS
    // no pulse means an all-zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("non-pulse word carries data");

    // one word in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is in work");

    // divider runs only after an evaluation
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && !$past(cmd.div_step)) |-> $past(cmd.eval))
        else $error("divider started without evaluation");
`endif

endmodule

// ===== src/ppl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppl_ctrl: sequencing controller
// Steps one word through multiply, evaluate, divide when needed and output load.
// ----------------------------------------------------------------------------
module ppl_ctrl #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  ppl_pkg::ppl_status_t status,
    output ppl_pkg::ppl_cmd_t    cmd
);
    import ppl_pkg::*;

    localparam int CNT_W = $clog2(FRACTION_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_EVAL,
        S_DIV,
        S_WRITE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    logic               out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    // command decode
    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && s_tvalid;
        cmd.mult     = (state_reg == S_MULT);
        cmd.eval     = (state_reg == S_EVAL);
        cmd.div_step = (state_reg == S_DIV);
        cmd.load_out = (state_reg == S_WRITE) && out_free;
    end

    // state, step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= S_MULT;
                end
                S_MULT:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    cnt_reg <= CNT_W'(FRACTION_BITS - 1);
                    if (status.need_div)
                        state_reg <= S_DIV;
                    else
                        state_reg <= S_WRITE;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/ppl_datapath.sv =====
// ----------------------------------------------------------------------------
// ppl_datapath: phase accumulator, pulse detector and fraction divider
// Holds configuration, phase state, restoring divider and output word.
// ----------------------------------------------------------------------------
module ppl_datapath #(
    parameter int PHASE_BITS    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ppl_pkg::ADDR_W-1:0]            cfg_addr,
    input  logic [ppl_pkg::SCALE_W-1:0]           cfg_data,
    input  logic [ppl_pkg::PITCH_W-1:0]           pitch,
    input  logic                                  voiced,
    input  logic                                  restart,
    input  ppl_pkg::ppl_cmd_t                     cmd,
    output ppl_pkg::ppl_status_t                  status,
    output logic                                  pulse,
    output logic [ppl_pkg::COUNT_W-1:0]           pulse_index,
    output logic [ppl_pkg::FRAC_W-1:0]            shift_fraction
);
    import ppl_pkg::*;

    localparam int PB = PHASE_BITS;
    localparam int FB = FRACTION_BITS;

    // configuration
    logic [SCALE_W-1:0] turn_scale_reg;
    logic [PITCH_W-1:0] default_pitch_reg;

    // captured word and product
    logic [PITCH_W-1:0] p_reg;
    logic               restart_reg;
    logic [PROD_W-1:0]  prod_reg;

    // phase state
    logic [PB-1:0]      phase_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               first_reg;

    // divider
    logic [PB:0]        rem_reg;
    logic [PB:0]        den_reg;
    logic [FB-1:0]      quo_reg;
    logic               pulse_reg;
    logic [COUNT_W-1:0] index_reg;

    // output word
    logic               out_pulse_reg;
    logic [COUNT_W-1:0] out_index_reg;
    logic [FRAC_W-1:0]  out_frac_reg;

    // evaluation signals
    logic [PB-1:0]      inc;
    logic [PB-1:0]      next_phase;
    logic [PB-1:0]      phase_gap;
    logic [PB:0]        turn;
    logic [PB:0]        num;
    logic [PB:0]        den;
    logic               start;
    logic               crossed;
    logic               sat;
    logic [PB+1:0]      rem_sh;
    logic               ge;
    logic [PB+1:0]      rem_sub;
    logic [FB+FRAC_W-1:0] quo_ext;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_scale_reg    <= TURN_SCALE_RST;
            default_pitch_reg <= DEFAULT_PITCH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TURN_SCALE:    turn_scale_reg    <= cfg_data;
                REG_DEFAULT_PITCH: default_pitch_reg <= cfg_data[PITCH_W-1:0];
                default:           ;
            endcase
        end
    end

    // phase step and pulse test
    assign inc        = prod_reg[PROD_W-1 -: PB];
    assign start      = first_reg || restart_reg;
    assign next_phase = phase_reg + inc;
    assign phase_gap  = (next_phase >= phase_reg) ? (next_phase - phase_reg)
                                                  : (phase_reg - next_phase);
    assign crossed    = (phase_gap > {1'b1, {(PB-1){1'b0}}});
    assign turn       = {1'b1, {PB{1'b0}}};
    assign num        = turn - {1'b0, phase_reg};
    assign den        = {1'b0, next_phase} + turn - {1'b0, phase_reg};
    assign sat        = (num >= den);

    assign status.need_div = !start && crossed && !sat;

    // restoring division step
    assign rem_sh  = {rem_reg, 1'b0};
    assign ge      = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // capture, multiply, evaluate, divide
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            p_reg       <= voiced ? pitch : default_pitch_reg;
            restart_reg <= restart;
        end
        if (cmd.mult)
            prod_reg <= PROD_W'(p_reg) * PROD_W'(turn_scale_reg);
        if (cmd.eval)
        begin
            pulse_reg <= !start && crossed;
            index_reg <= (!start && crossed) ? count_reg : '0;
            rem_reg   <= num;
            den_reg   <= den;
            if (!start && crossed && sat)
                quo_reg <= '1;
            else
                quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? rem_sub[PB:0] : rem_sh[PB:0];
            quo_reg <= {quo_reg[FB-2:0], ge};
        end
        if (cmd.load_out)
        begin
            out_pulse_reg <= pulse_reg;
            out_index_reg <= index_reg;
            out_frac_reg  <= quo_ext[FRAC_W-1:0];
        end
    end

    assign quo_ext = {{FRAC_W{1'b0}}, quo_reg};

    // phase and sample counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            count_reg <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.eval)
        begin
            first_reg <= 1'b0;
            if (start)
            begin
                phase_reg <= inc;
                count_reg <= '0;
            end
            else
            begin
                phase_reg <= next_phase;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign pulse          = out_pulse_reg;
    assign pulse_index    = out_index_reg;
    assign shift_fraction = out_frac_reg;

endmodule

// ===== tb/ppl_checker.sv =====
// ----------------------------------------------------------------------------
// ppl_checker: scoreboard for the pitch pulse locator
// Follows register writes and accepted input words, keeps its own phase and
// sample counter, and holds the pulse results each word must produce. Every
// accepted output word is compared field by field with the oldest one held.
// ----------------------------------------------------------------------------
module ppl_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ppl_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [ppl_pkg::SCALE_W-1:0]  cfg_data,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] pitch
    input  logic [1:0]                   s_tuser,   // [0] voiced, [1] restart
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [47:0]                  m_tdata,   // [31:0] pulse_index,
                                                    // [47:32] shift_fraction
    input  logic [0:0]                   m_tuser,   // [0] pulse
    output int                           errors,
    output int                           pending,
    output int                           pulses
);
    import ppl_pkg::*;

    typedef struct packed {
        logic               pulse;
        logic [COUNT_W-1:0] index;
        logic [FRAC_W-1:0]  frac;
    } pulse_rec_t;

    // mirrored registers and locator state
    logic [SCALE_W-1:0] turn_scale_r;
    logic [PITCH_W-1:0] default_pitch_r;
    logic [31:0]        phase_r;
    logic [COUNT_W-1:0] sample_idx;
    logic               at_start;

    pulse_rec_t pulse_q[$];
    int         fail_count = 0;
    int         pulse_count = 0;

    assign errors = fail_count;
    assign pulses = pulse_count;

    task automatic report_mismatch(input string msg);
        $display("ppl_checker: mismatch: %s", msg);
        fail_count++;
    endtask

    // advance the phase by one sample and work out where a pulse lands
    function automatic pulse_rec_t locate_pulse(input logic [PITCH_W-1:0] pitch_in,
                                                input logic voiced_in,
                                                input logic restart_in);
        pulse_rec_t         rec;
        logic [PITCH_W-1:0] pitch_used;
        logic [PROD_W-1:0]  product;
        logic [31:0]        step, prev, nxt, gap;
        logic [63:0]        numer, denom, quot;
        rec = '0;
        pitch_used = voiced_in ? pitch_in : default_pitch_r;
        product = PROD_W'(pitch_used) * PROD_W'(turn_scale_r);
        step = product[47:16];
        // first sample of an utterance only seeds the phase
        if (at_start || restart_in) begin
            phase_r = step;
            sample_idx = '0;
            at_start = 1'b0;
            return rec;
        end
        prev = phase_r;
        nxt = prev + step;
        gap = (nxt >= prev) ? nxt - prev : prev - nxt;
        if (gap > 32'h8000_0000) begin
            numer = 64'h1_0000_0000 - 64'(prev);
            denom = 64'(nxt) + numer;
            rec.pulse = 1'b1;
            rec.index = sample_idx;
            // quotient of one or more saturates just below one sample
            if (numer >= denom)
                rec.frac = '1;
            else
            begin
                quot = (numer << FRAC_W) / denom;
                rec.frac = quot[FRAC_W-1:0];
            end
        end
        phase_r = nxt;
        sample_idx = sample_idx + 1'b1;
        return rec;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pulse_rec_t want;
        if (!rst_n)
        begin
            turn_scale_r = TURN_SCALE_RST;
            default_pitch_r = DEFAULT_PITCH_RST;
            phase_r = '0;
            sample_idx = '0;
            at_start = 1'b1;
            pulse_q.delete();
            pending <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                if (cfg_addr == REG_TURN_SCALE)
                    turn_scale_r = cfg_data;
                else if (cfg_addr == REG_DEFAULT_PITCH)
                    default_pitch_r = cfg_data[PITCH_W-1:0];
            end
            // result word against the oldest held expectation
            if (m_tvalid && m_tready)
            begin
                if (pulse_q.size() == 0)
                    report_mismatch($sformatf("result word with none expected, tdata %h",
                                              m_tdata));
                else
                begin
                    want = pulse_q.pop_front();
                    if (m_tuser[0] !== want.pulse)
                        report_mismatch($sformatf("pulse %b, expected %b",
                                                  m_tuser[0], want.pulse));
                    if (m_tdata[31:0] !== want.index)
                        report_mismatch($sformatf("pulse_index %0d, expected %0d",
                                                  m_tdata[31:0], want.index));
                    if (m_tdata[47:32] !== want.frac)
                        report_mismatch($sformatf("shift_fraction %h, expected %h",
                                                  m_tdata[47:32], want.frac));
                    if (want.pulse)
                        pulse_count++;
                end
            end
            // new sample word
            if (s_tvalid && s_tready)
                pulse_q.push_back(locate_pulse(s_tdata, s_tuser[0], s_tuser[1]));
            pending <= pulse_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for pitch_pulse_locator_core
// Drives sample words through several register settings, starting with short
// directed sequences for wraps, restarts, unvoiced samples, large steps and
// fraction saturation, then random samples with random idling on both sides
// and one long output stall. The checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import ppl_pkg::*;

    localparam int SETTLE      = 30;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we = 1'b0;
    logic [ADDR_W-1:0]  cfg_addr = REG_TURN_SCALE;
    logic [SCALE_W-1:0] cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata = '0;    // [15:0] pitch
    logic [1:0]         s_tuser = '0;    // [0] voiced, [1] restart
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [47:0]        m_tdata;         // [31:0] pulse_index, [47:32] shift_fraction
    logic [0:0]         m_tuser;         // [0] pulse

    int  errors, pending, pulses;
    int  samples_sent = 0;
    int  settings_used = 1;
    int  cycles = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;

    pitch_pulse_locator_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ppl_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending),
        .pulses   (pulses)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // output side: random back-pressure, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 30);
        end
    end

    // offer one sample word and wait for it to be taken
    task automatic send_sample(input logic [15:0] pitch, input logic voiced,
                               input logic restart);
        if (!calm && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pitch;
        s_tuser  <= {restart, voiced};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        samples_sent++;
    endtask

    task automatic send_random(input int count);
        logic [15:0] pitch;
        int          sel;
        repeat (count)
        begin
            sel = $urandom_range(99);
            if (sel < 8)
                pitch = 16'h0000;
            else if (sel < 16)
                pitch = 16'hFFFF;
            else
                pitch = 16'($urandom);
            send_sample(pitch, $urandom_range(99) < 75, $urandom_range(99) < 3);
        end
    endtask

    // let every expected word come back, then let the bench settle with no input
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [SCALE_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [SCALE_W-1:0] scale, input logic [PITCH_W-1:0] dflt);
        write_reg(REG_TURN_SCALE, scale);
        write_reg(REG_DEFAULT_PITCH, {16'h0000, dflt});
        settings_used++;
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unvoiced start, fast pitch until the phase wraps
        send_sample(16'h0000, 1'b0, 1'b1);
        repeat (14) send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'h1234, 1'b0, 1'b0);
        send_sample(16'h0000, 1'b1, 1'b1);
        send_sample(16'h0000, 1'b1, 1'b0);
        drain();

        // half-turn scale: land exactly on zero so the fraction saturates
        set_regs(32'h8000_0000, 16'd8000);
        send_sample(16'h0000, 1'b1, 1'b1);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'h0002, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        drain();

        // full scale: a step above half a turn with no wrap
        set_regs(32'hFFFF_FFFF, 16'hFFFF);
        send_sample(16'h0000, 1'b1, 1'b1);
        send_sample(16'd40000, 1'b1, 1'b0);
        send_sample(16'h0000, 1'b0, 1'b0);
        drain();

        // random phases over several settings
        set_regs(TURN_SCALE_RST, DEFAULT_PITCH_RST);
        send_random(100);
        drain();

        set_regs(32'h0000_0000, 16'h0000);
        send_random(60);
        drain();

        calm = 1'b1;
        set_regs(32'hFFFF_FFFF, 16'hFFFF);
        send_random(100);
        drain();
        calm = 1'b0;

        set_regs($urandom, 16'($urandom));
        hold_req = 1'b1;
        send_random(100);
        drain();

        set_regs(32'h0400_0000, 16'($urandom));
        send_random(100);
        drain();

        $display("tb_top: %0d samples over %0d register settings, %0d pulses located",
                 samples_sent, settings_used, pulses);
        $display("tb_top: included wraps, restarts, saturation and a %0d-cycle output stall",
                 HOLD_CYCLES);
        if (errors == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
